// File: hw/rtl/median_of_two_sorted_lists_defines.svh
// Assertion macros shared by the median block RTL.
`ifndef MEDIAN_OF_TWO_SORTED_LISTS_DEFINES_SVH
`define MEDIAN_OF_TWO_SORTED_LISTS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define MTS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/mts_pkg.sv
// Types and constants for the median block.
package mts_pkg;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int MEDIAN_W = 33;

    localparam logic [CMD_W-1:0] CMD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MEDIAN = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } walk_stat_t;

endpackage

// File: hw/rtl/mts_ram.sv
// Generic simple dual-port RAM with registered read.
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/mts_walk.sv
// Merge walker: steps through both list memories and sums the middle items.
module mts_walk #(
    parameter int LIST_DEPTH = 1024,
    localparam int CW = $clog2(LIST_DEPTH + 1),
    localparam int AW = $clog2(LIST_DEPTH),
    localparam int TW = CW + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [CW-1:0]                 n1,
    input  logic [CW-1:0]                 n2,
    input  logic [mts_pkg::VALUE_W-1:0]   rd1,
    input  logic [mts_pkg::VALUE_W-1:0]   rd2,
    output logic [AW-1:0]                 addr1,
    output logic [AW-1:0]                 addr2,
    output mts_pkg::walk_stat_t           stat,
    output logic [mts_pkg::MEDIAN_W-1:0]  sum
);

    import mts_pkg::*;

    `include "median_of_two_sorted_lists_defines.svh"

    logic                busy_reg;
    logic [CW-1:0]       i_reg;
    logic [CW-1:0]       j_reg;
    logic [CW-1:0]       i_next;
    logic [CW-1:0]       j_next;
    logic [CW-1:0]       n1_reg;
    logic [CW-1:0]       n2_reg;
    logic [TW-1:0]       k_reg;
    logic [TW-1:0]       lo_reg;
    logic [TW-1:0]       hi_reg;
    logic [TW-1:0]       total;
    logic [MEDIAN_W-1:0] sum_reg;
    logic [MEDIAN_W-1:0] sum_next;
    logic [MEDIAN_W-1:0] pick;
    logic [MEDIAN_W-1:0] addend;
    logic                take_first;
    logic                at_lo;
    logic                at_hi;

    assign total = TW'(n1) + TW'(n2);

    assign take_first = (j_reg >= n2_reg)
                     || ((i_reg < n1_reg) && ($signed(rd1) <= $signed(rd2)));
    assign pick = take_first ? {rd1[VALUE_W-1], rd1} : {rd2[VALUE_W-1], rd2};
    assign at_lo = (k_reg == lo_reg);
    assign at_hi = (k_reg == hi_reg);

    always_comb
    begin
        if (at_lo && at_hi)
        begin
            addend = {pick[MEDIAN_W-2:0], 1'b0};
        end
        else if (at_lo || at_hi)
        begin
            addend = pick;
        end
        else
        begin
            addend = '0;
        end
    end

    assign sum_next = sum_reg + addend;
    assign i_next   = i_reg + CW'(take_first);
    assign j_next   = j_reg + CW'(!take_first);

    // advance the read addresses in the same cycle the pick is made
    assign addr1 = busy_reg ? i_next[AW-1:0] : '0;
    assign addr2 = busy_reg ? j_next[AW-1:0] : '0;

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && at_hi;
    assign sum       = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && at_hi)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            i_reg   <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
            n1_reg  <= n1;
            n2_reg  <= n2;
            lo_reg  <= TW'(total - TW'(1)) >> 1;
            hi_reg  <= total >> 1;
            sum_reg <= '0;
        end
        else if (busy_reg)
        begin
            i_reg   <= i_next;
            j_reg   <= j_next;
            k_reg   <= k_reg + TW'(1);
            sum_reg <= sum_next;
        end
    end

    `MTS_ASSERT_IMPLY(a_walk_index_sum, clk, rst_n, busy_reg, (TW'(i_reg) + TW'(j_reg)) == k_reg)
    `MTS_ASSERT_NEXT(a_walk_done_idle, clk, rst_n, stat.done && !start, !busy_reg)

endmodule

// File: hw/rtl/median_of_two_sorted_lists.sv
// Median of two lists: appends go to two list memories; a median request walks the merge of
// both lists one position per cycle, reading one entry of each memory per cycle, and returns
// twice the median; both lists are emptied when the request is accepted. New items wait until
// the walk, if any, is done and the result is loaded for output, which waits for the previous
// result to be taken. Appends to a full list are dropped and reported with the next result.
module median_of_two_sorted_lists #(
    parameter int LIST_DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  logic [mts_pkg::CMD_W-1:0]            cmd,
    input  logic signed [mts_pkg::VALUE_W-1:0]   value,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic signed [mts_pkg::MEDIAN_W-1:0]  median_twice,
    output logic                                 empty_res,
    output logic                                 overflowed
);

    import mts_pkg::*;

    `include "median_of_two_sorted_lists_defines.svh"

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = $clog2(LIST_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CW-1:0]       first_count_reg;
    logic [CW-1:0]       second_count_reg;
    logic                ovf_reg;
    logic                res_valid_reg;
    logic                empty_hold_reg;
    logic                ovf_hold_reg;
    logic [MEDIAN_W-1:0] median_twice_reg;
    logic                empty_res_reg;
    logic                overflowed_reg;

    logic                accept;
    logic                first_full;
    logic                second_full;
    logic                we1;
    logic                we2;
    logic                is_median;
    logic                lists_empty;
    logic                walk_start;
    logic                load_out;
    logic [AW-1:0]       raddr1;
    logic [AW-1:0]       raddr2;
    logic [VALUE_W-1:0]  rd1;
    logic [VALUE_W-1:0]  rd2;
    logic [MEDIAN_W-1:0] walk_sum;
    walk_stat_t          walk_stat;

    assign req_ready   = (state_reg == ST_IDLE);
    assign accept      = req_valid && req_ready;
    assign first_full  = (first_count_reg == CW'(LIST_DEPTH));
    assign second_full = (second_count_reg == CW'(LIST_DEPTH));
    assign we1         = accept && (cmd == CMD_FIRST) && !first_full;
    assign we2         = accept && (cmd == CMD_SECOND) && !second_full;
    assign is_median   = accept && (cmd == CMD_MEDIAN);
    assign lists_empty = (first_count_reg == '0) && (second_count_reg == '0);
    assign walk_start  = is_median && !lists_empty;
    assign load_out    = (state_reg == ST_HOLD) && (!res_valid_reg || res_ready);

    mts_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_first_ram (
        .clk   (clk),
        .we    (we1),
        .waddr (first_count_reg[AW-1:0]),
        .wdata (value),
        .raddr (raddr1),
        .rdata (rd1)
    );

    mts_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_second_ram (
        .clk   (clk),
        .we    (we2),
        .waddr (second_count_reg[AW-1:0]),
        .wdata (value),
        .raddr (raddr2),
        .rdata (rd2)
    );

    mts_walk #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (walk_start),
        .n1    (first_count_reg),
        .n2    (second_count_reg),
        .rd1   (rd1),
        .rd2   (rd2),
        .addr1 (raddr1),
        .addr2 (raddr2),
        .stat  (walk_stat),
        .sum   (walk_sum)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (walk_start)
                begin
                    state_next = ST_WALK;
                end
                else if (is_median)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_WALK:
            begin
                if (walk_stat.done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            ovf_reg          <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (is_median)
            begin
                first_count_reg  <= '0;
                second_count_reg <= '0;
                ovf_reg          <= 1'b0;
            end
            else
            begin
                if (we1)
                begin
                    first_count_reg <= first_count_reg + CW'(1);
                end
                if (we2)
                begin
                    second_count_reg <= second_count_reg + CW'(1);
                end
                // drop pushes to a full list
                if (accept && (((cmd == CMD_FIRST) && first_full)
                            || ((cmd == CMD_SECOND) && second_full)))
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_median)
        begin
            empty_hold_reg <= lists_empty;
            ovf_hold_reg   <= ovf_reg;
        end
        if (load_out)
        begin
            median_twice_reg <= empty_hold_reg ? '0 : walk_sum;
            empty_res_reg    <= empty_hold_reg;
            overflowed_reg   <= ovf_hold_reg;
        end
    end

    assign res_valid    = res_valid_reg;
    assign median_twice = median_twice_reg;
    assign empty_res    = empty_res_reg;
    assign overflowed   = overflowed_reg;

    `MTS_ASSERT_IMPLY(a_walk_in_walk_state, clk, rst_n, walk_stat.busy, state_reg == ST_WALK)
    `MTS_ASSERT_IMPLY(a_count_in_range, clk, rst_n, 1'b1, first_count_reg <= CW'(LIST_DEPTH) && second_count_reg <= CW'(LIST_DEPTH))
    `MTS_ASSERT_NEXT(a_hold_loads, clk, rst_n, state_reg == ST_HOLD && !res_valid_reg, res_valid_reg && state_reg == ST_IDLE)
    `MTS_ASSERT_IMPLY(a_empty_zero, clk, rst_n, res_valid_reg && empty_res_reg, median_twice_reg == '0)

endmodule

// File: tb/sv/tb_top.sv
// Testbench for median_of_two_sorted_lists: random handshakes, predicted medians, overflow.
module tb_top;
    import mts_pkg::*;

    localparam int LIST_DEPTH = 1024;
    localparam int RANDOM_ITEMS = 600;
    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [MEDIAN_W-1:0] twice;
        logic                       empty;
        logic                       ovf;
    } median_res_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_ready;
    logic [CMD_W-1:0]           cmd;
    logic signed [VALUE_W-1:0]  value;
    logic                       res_valid;
    logic                       res_ready;
    logic signed [MEDIAN_W-1:0] median_twice;
    logic                       empty_res;
    logic                       overflowed;

    logic signed [VALUE_W-1:0] list_a [LIST_DEPTH];
    logic signed [VALUE_W-1:0] list_b [LIST_DEPTH];
    int          len_a;
    int          len_b;
    bit          drop_seen;
    median_res_t median_q [$];
    int          err_count;
    int          tx_calm_left;
    int          rx_stall_left;
    int          rx_calm_left;
    int          rx_hold_left;
    int          rx_hold_req;
    int          run_buf [$];
    int          run_a [$];
    int          run_b [$];

    median_of_two_sorted_lists #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .cmd(cmd),
        .value(value),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .median_twice(median_twice),
        .empty_res(empty_res),
        .overflowed(overflowed)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [MEDIAN_W-1:0] merged_median_twice();
        int     total;
        int     lo;
        int     hi;
        int     i;
        int     j;
        longint acc;
        longint pick;
        bit     take_a;
        total = len_a + len_b;
        lo = (total - 1) / 2;
        hi = total / 2;
        i = 0;
        j = 0;
        acc = 0;
        for (int k = 0; k <= hi; k++)
        begin
            if (j >= len_b)
                take_a = 1'b1;
            else if (i >= len_a)
                take_a = 1'b0;
            else
                take_a = (list_a[i] <= list_b[j]);
            if (take_a)
            begin
                pick = longint'(list_a[i]);
                i++;
            end
            else
            begin
                pick = longint'(list_b[j]);
                j++;
            end
            if (k == lo)
                acc += pick;
            if (k == hi)
                acc += pick;
        end
        return acc[MEDIAN_W-1:0];
    endfunction

    function automatic void note_mismatch(string msg);
        if (err_count < 10)
            $display("mismatch: %s", msg);
        err_count++;
    endfunction

    // Check results first, then fold the accepted item into the prediction.
    always @(posedge clk)
    begin
        median_res_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (median_q.size() == 0)
                    note_mismatch($sformatf("unexpected result %0d empty=%0b ovf=%0b",
                                            median_twice, empty_res, overflowed));
                else
                begin
                    want = median_q.pop_front();
                    if (median_twice !== want.twice || empty_res !== want.empty
                        || overflowed !== want.ovf)
                        note_mismatch($sformatf(
                            "expected median_twice=%0d empty=%0b ovf=%0b, got %0d %0b %0b",
                            want.twice, want.empty, want.ovf,
                            median_twice, empty_res, overflowed));
                end
            end
            if (req_valid && req_ready)
            begin
                case (cmd)
                    CMD_FIRST:
                    begin
                        if (len_a < LIST_DEPTH)
                        begin
                            list_a[len_a] = value;
                            len_a++;
                        end
                        else
                            drop_seen = 1'b1;
                    end
                    CMD_SECOND:
                    begin
                        if (len_b < LIST_DEPTH)
                        begin
                            list_b[len_b] = value;
                            len_b++;
                        end
                        else
                            drop_seen = 1'b1;
                    end
                    CMD_MEDIAN:
                    begin
                        if (len_a + len_b == 0)
                        begin
                            want.twice = '0;
                            want.empty = 1'b1;
                        end
                        else
                        begin
                            want.twice = merged_median_twice();
                            want.empty = 1'b0;
                        end
                        want.ovf = drop_seen;
                        median_q.push_back(want);
                        len_a = 0;
                        len_b = 0;
                        drop_seen = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result side: random stalls, calm stretches, and a long hold on request.
    initial
    begin
        res_ready = 1'b0;
        rx_stall_left = 0;
        rx_calm_left = 0;
        rx_hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req > 0)
            begin
                rx_hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_hold_left > 0)
            begin
                res_ready <= 1'b0;
                rx_hold_left--;
            end
            else if (rx_stall_left > 0)
            begin
                res_ready <= 1'b0;
                rx_stall_left--;
            end
            else
            begin
                res_ready <= 1'b1;
                if (rx_calm_left > 0)
                    rx_calm_left--;
                else if ($urandom_range(0, 99) < 30)
                    rx_stall_left = pick_gap();
                if ($urandom_range(0, 199) == 0)
                    rx_calm_left = $urandom_range(50, 300);
            end
        end
    end

    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("FAIL median_of_two_sorted_lists");
        $finish;
    end

    task automatic send_item(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v);
        int gap;
        if (tx_calm_left > 0)
        begin
            gap = 0;
            tx_calm_left--;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 99) == 0)
                tx_calm_left = $urandom_range(30, 150);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        cmd <= c;
        value <= v;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic make_run(input int n, input bit unsorted);
        int     mode;
        longint cur;
        longint step_max;
        mode = $urandom_range(0, 3);
        case (mode)
            0:
            begin
                cur = longint'($signed($urandom));
                step_max = 1 << 24;
            end
            1:
            begin
                cur = $urandom_range(0, 16) - 8;
                step_max = 2;
            end
            2:
            begin
                cur = VAL_MIN + $urandom_range(0, 1000);
                step_max = 1 << 30;
            end
            default:
            begin
                cur = VAL_MAX - $urandom_range(0, 2000);
                step_max = 300;
            end
        endcase
        run_buf.delete();
        for (int i = 0; i < n; i++)
        begin
            if (unsorted)
                run_buf.push_back(int'($urandom));
            else
                run_buf.push_back(int'(cur));
            cur = cur + $urandom_range(0, int'(step_max));
            if (cur > VAL_MAX)
                cur = VAL_MAX;
        end
    endtask

    task automatic test_directed();
        send_item(CMD_MEDIAN, 32'sd0);
        send_item(CMD_UNUSED, -32'sd1);
        send_item(CMD_MEDIAN, -32'sd1);
        send_item(CMD_FIRST, 32'sh7FFF_FFFF);
        send_item(CMD_MEDIAN, 32'sd0);
        send_item(CMD_SECOND, 32'sh8000_0000);
        send_item(CMD_MEDIAN, 32'sd0);
        send_item(CMD_FIRST, 32'sh8000_0000);
        send_item(CMD_SECOND, 32'sh8000_0000);
        send_item(CMD_MEDIAN, 32'sd0);
        send_item(CMD_SECOND, 32'sh7FFF_FFFF);
        send_item(CMD_FIRST, 32'sh7FFF_FFFF);
        send_item(CMD_MEDIAN, 32'sd0);
        send_item(CMD_FIRST, -32'sd1);
        send_item(CMD_UNUSED, 32'sh5555_AAAA);
        send_item(CMD_FIRST, 32'sd0);
        send_item(CMD_SECOND, 32'sd1);
        send_item(CMD_MEDIAN, 32'sd0);
        send_item(CMD_FIRST, 32'sh8000_0000);
        send_item(CMD_SECOND, 32'sh7FFF_FFFF);
        send_item(CMD_MEDIAN, 32'sd0);
        send_item(CMD_FIRST, 32'sd5);
        send_item(CMD_FIRST, 32'sd1);
        send_item(CMD_SECOND, 32'sd3);
        send_item(CMD_MEDIAN, 32'sd0);
    endtask

    task automatic send_set(input int na, input int nb, input bit unsorted);
        int ia;
        int ib;
        make_run(na, unsorted);
        run_a = run_buf;
        make_run(nb, unsorted && ($urandom_range(0, 1) == 1));
        run_b = run_buf;
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            if ($urandom_range(0, 24) == 0)
                send_item(CMD_UNUSED, $urandom);
            if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1))
            begin
                send_item(CMD_FIRST, run_a[ia]);
                ia++;
            end
            else
            begin
                send_item(CMD_SECOND, run_b[ib]);
                ib++;
            end
        end
        send_item(CMD_MEDIAN, $urandom);
    endtask

    task automatic test_random();
        int sent;
        int na;
        int nb;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            na = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            nb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            send_set(na, nb, $urandom_range(0, 9) == 0);
            sent += na + nb + 1;
        end
    endtask

    task automatic test_backpressure();
        rx_hold_req = HOLD_CYCLES;
        for (int s = 0; s < 6; s++)
            send_set($urandom_range(1, 6), $urandom_range(0, 6), 1'b0);
    endtask

    task automatic test_overflow();
        for (int k = 0; k < LIST_DEPTH + 3; k++)
            send_item(CMD_FIRST, int'(VAL_MIN + longint'(k) * 4_000_000));
        send_item(CMD_SECOND, -32'sd7);
        send_item(CMD_SECOND, 32'sd9);
        send_item(CMD_MEDIAN, 32'sd0);
        for (int k = 0; k < LIST_DEPTH + 6; k++)
            send_item(CMD_SECOND, int'(VAL_MAX - longint'(LIST_DEPTH + 5 - k) * 3_000_000));
        for (int k = 0; k < LIST_DEPTH; k++)
            send_item(CMD_FIRST, int'(VAL_MIN + longint'(k) * 2_500_000));
        send_item(CMD_MEDIAN, 32'sd0);
        send_item(CMD_MEDIAN, 32'sd0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        cmd = CMD_FIRST;
        value = '0;
        len_a = 0;
        len_b = 0;
        drop_seen = 1'b0;
        err_count = 0;
        tx_calm_left = 0;
        rx_hold_req = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random();
        test_backpressure();
        test_overflow();

        @(negedge clk);
        req_valid <= 1'b0;
        while (median_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && median_q.size() == 0)
            $display("PASS median_of_two_sorted_lists");
        else
            $display("FAIL median_of_two_sorted_lists");
        $finish;
    end
endmodule
